FILE: design/sclp_pkg.sv
// Shared types and constants of the serial command line parser.
package sclp_pkg;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] echo_byte;
    logic [6:0] command_number;
    logic       last;
  } result_t;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] DIGIT_BASE   = 8'h30;
  localparam logic [7:0] DIGIT_LAST   = 8'h39;

  localparam int HEADER_LEN = 4;
  localparam int CHECK_LEN  = HEADER_LEN + 2;
  localparam int MAX_RESULTS = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic REG_HEADER_WORD   = 1'b0;
  localparam logic REG_COMMAND_COUNT = 1'b1;

  localparam logic [31:0] HEADER_WORD_RESET   = 32'h656E2B63;
  localparam logic [6:0]  COMMAND_COUNT_RESET = 7'd8;

endpackage

FILE: design/sclp_result_fifo.sv
// Result queue of the parser: takes up to three results a cycle, delivers one while out_stall is low.
module sclp_result_fifo
  import sclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    push_data [MAX_RESULTS],
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_data
);

  result_t                 q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic [FIFO_CNT_W-1:0]   count_next;
  logic [FIFO_CNT_W-1:0]   free_slots;
  logic                    pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q[rd_ptr];

  // Free slots count the entry that leaves in this cycle.
  assign free_slots = FIFO_CNT_W'(FIFO_DEPTH) - count + FIFO_CNT_W'(pop);
  assign room       = (free_slots >= FIFO_CNT_W'(MAX_RESULTS));

  assign count_next = count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        q[wr_ptr + FIFO_PTR_W'(k)] <= push_data[k];
      end
    end
  end

endmodule

FILE: design/serial_command_line_parser.sv
// Top level of the serial command line editor and parser.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ----------------------------------------
//  input     in         in_valid / in_stall     rx_byte
//  result    out        out_valid / out_stall   kind, echo_byte, command_number, last
//  config    in         APB psel/penable/pready paddr, pwdata, prdata
//
// One byte is taken into the input register per cycle while in_stall is low; it
// is processed once the result queue has room for three results, so the input side
// runs at one byte a cycle while the output side keeps up. The result port
// delivers one transaction a cycle while out_stall is low, and a byte yields 1 to 3
// results (backspace 3, carriage return or full line 2, any other byte 1).
// Reset clears the write position, queue and input register's full flag and resets the config
// registers to their defaults; stalls on the result side back up through the queue into in_stall.
module serial_command_line_parser
  import sclp_pkg::*;
#(
  parameter int LINE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  echo_byte,
  output logic [6:0]  command_number,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int POS_W = $clog2(LINE_SIZE);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(LINE_SIZE - 1);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(CHECK_LEN);

  // Configuration registers.
  logic [31:0] header_word;
  logic [6:0]  command_count;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word   <= HEADER_WORD_RESET;
      command_count <= COMMAND_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_HEADER_WORD:   header_word   <= pwdata;
        REG_COMMAND_COUNT: command_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register index sits at bit 2; the low address bits are byte lanes.
  always_comb begin
    unique case (paddr[2])
      REG_HEADER_WORD:   prdata = header_word;
      REG_COMMAND_COUNT: prdata = {25'd0, command_count};
      default:           prdata = '0;
    endcase
  end

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       room;
  logic       adv;

  assign adv      = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // Line state. Only the first header-plus-digits slots of the line are ever
  // read back, so just those are kept; each sits at a fixed slot.
  logic [POS_W-1:0] write_position;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       line_head [CHECK_LEN];

  logic             is_bs;
  logic             is_cr;
  logic             header_ok;
  logic             digits_ok;
  logic [3:0]       d_hi;
  logic [3:0]       d_lo;
  logic [6:0]       number;
  logic             line_ok;

  assign is_bs = (in_byte == CH_BACKSPACE);
  assign is_cr = (in_byte == CH_CR);

  always_comb begin
    header_ok = 1'b1;
    for (int i = 0; i < HEADER_LEN; i++) begin
      if (line_head[i] != header_word[8*(HEADER_LEN-1-i) +: 8]) begin
        header_ok = 1'b0;
      end
    end
  end

  assign digits_ok = (line_head[HEADER_LEN]   >= DIGIT_BASE) &&
                     (line_head[HEADER_LEN]   <= DIGIT_LAST) &&
                     (line_head[HEADER_LEN+1] >= DIGIT_BASE) &&
                     (line_head[HEADER_LEN+1] <= DIGIT_LAST);

  // Digit value is the low nibble once the byte is known to be a digit.
  assign d_hi   = line_head[HEADER_LEN][3:0];
  assign d_lo   = line_head[HEADER_LEN+1][3:0];
  assign number = (7'(d_hi) << 3) + (7'(d_hi) << 1) + 7'(d_lo);

  // The carriage return must land right after the two digits.
  assign line_ok = (write_position == CHECK_POS) && header_ok && digits_ok &&
                   (number < command_count);

  // Results of the byte in the input register.
  result_t    res [MAX_RESULTS];
  logic [1:0] res_n;
  logic [1:0] push_n;

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '{kind: KIND_ECHO, echo_byte: 8'd0, command_number: 7'd0, last: 1'b0};
    end
    res[0].echo_byte = in_byte;
    res_n    = 2'd1;
    pos_next = write_position + 1'b1;
    if (is_bs) begin
      // Rub out: back, space, back; step the position back, but not below zero.
      res_n            = 2'd3;
      res[0].echo_byte = CH_BACKSPACE;
      res[1].echo_byte = CH_SPACE;
      res[2].echo_byte = CH_BACKSPACE;
      res[2].last      = 1'b1;
      pos_next = (write_position == '0) ? '0 : write_position - 1'b1;
    end else if (is_cr) begin
      res_n       = 2'd2;
      res[1].kind = line_ok ? KIND_ACCEPT : KIND_INVALID;
      res[1].command_number = line_ok ? number : 7'd0;
      res[1].last = 1'b1;
      pos_next    = '0;
    end else if (write_position == LAST_POS) begin
      // Line filled without a carriage return: drop it.
      res_n       = 2'd2;
      res[1].kind = KIND_TOO_LONG;
      res[1].last = 1'b1;
      pos_next    = '0;
    end else begin
      res[0].last = 1'b1;
    end
  end

  assign push_n = adv ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
    end else if (adv) begin
      write_position <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !is_bs && (write_position < CHECK_POS)) begin
      line_head[write_position[2:0]] <= in_byte;
    end
  end

  // Result queue.
  result_t out_data;

  sclp_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign echo_byte      = out_data.echo_byte;
  assign command_number = out_data.command_number;
  assign last           = out_data.last;

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    write_position <= LAST_POS)
    else $error("write position beyond the line store");

  a_verdict_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != KIND_ECHO) |-> out_data.last)
    else $error("line verdict not marked as final result");

  a_cr_rewinds: assert property (@(posedge clk) disable iff (rst)
    adv && is_cr |=> write_position == '0)
    else $error("carriage return did not rewind the line");

  a_number_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != KIND_ACCEPT) |-> out_data.command_number == 7'd0)
    else $error("command number set on a result that is not an accept");
`endif

endmodule
